>>> rtl/core/rgp_pkg.sv
// shared types, codes and constants of the receiver bitmap grant picker
package rgp_pkg;

	// field widths
	localparam int FLOW_W = 13;
	localparam int DNUM_W = 12;
	localparam int ECHO_W = 17;
	localparam int TGT_W  = 12;
	localparam int GNUM_W = 16;
	localparam int CMD_W  = 2;
	localparam int CFG_IDX_W = 2;

	// bitmap memory organization
	localparam int WORD_W = 64;
	localparam int BIT_W  = 6;

	// parameter defaults
	localparam int MAX_PACKETS_DEF = 4096;
	localparam int GRANT_BITS_DEF  = 16;

	// register reset values
	localparam logic [FLOW_W-1:0] FLOW_PACKETS_RST = 13'd4096;
	localparam logic [FLOW_W-1:0] DONE_GOAL_RST    = 13'd4096;
	localparam logic [FLOW_W-1:0] WINDOW_LIMIT_RST = 13'd0;

	// request commands
	localparam logic [CMD_W-1:0] CMD_RTS   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_GRANT = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FLOW_PACKETS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DONE_GOAL    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic clr_we;
		logic cap_in;
		logic rts_preset;
		logic echo_upd;
		logic rd_data;
		logic mark;
		logic set_dup;
		logic scan_ptr;
		logic scan_start;
		logic scan_rem;
		logic scan_rd;
		logic scan_next;
		logic ptr_found;
		logic ptr_end;
		logic grant_issue;
		logic grant_none;
		logic mod_start;
		logic out_load;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic             clr_last;
		logic [CMD_W-1:0] cmd;
		logic             dnum_ok;
		logic             bit_set;
		logic             ptr_lt_n;
		logic             n_zero;
		logic             start_lt_n;
		logic             scan_found;
		logic             scan_ended;
		logic             mod_busy;
	} dp_status_t;

endpackage

>>> rtl/core/rgp_ram.sv
// generic simple dual port ram with registered read
module rgp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/rgp_mod.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
module rgp_mod #(
	parameter int W = 13
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] rem
);

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  r_q;
	logic [W-1:0]  d_q;
	logic [W:0]    trial;
	logic [W:0]    trial_sub;

	// shift in next dividend bit, subtract divisor when it fits
	assign trial     = {r_q, d_q[W-1]};
	assign trial_sub = trial - {1'b0, divisor};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// partial remainder and dividend shift register
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			d_q <= dividend;
		end else if (busy_q) begin
			d_q <= {d_q[W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				r_q <= W'(trial_sub);
			end else begin
				r_q <= W'(trial);
			end
		end
	end

	assign busy = busy_q;
	assign rem  = r_q;

endmodule

>>> rtl/core/rgp_datapath.sv
// datapath: config registers, flow state, bitmap ram, word scanner and result register
module rgp_datapath import rgp_pkg::*; #(
	parameter int MAX_PACKETS = MAX_PACKETS_DEF,
	parameter int GRANT_BITS  = GRANT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_cmd_t                cmd,
	output dp_status_t               st,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [FLOW_W-1:0]        cfg_data,
	input  logic [CMD_W-1:0]         in_cmd,
	input  logic [DNUM_W-1:0]        in_data_number,
	input  logic signed [ECHO_W-1:0] in_echoed_grant,
	output logic                     was_duplicate,
	output logic                     flow_done,
	output logic [FLOW_W-1:0]        in_order_point,
	output logic [FLOW_W-1:0]        arrival_count,
	output logic [FLOW_W-1:0]        remaining_packets,
	output logic [TGT_W-1:0]         grant_target,
	output logic [GNUM_W-1:0]        grant_number,
	output logic                     grant_none,
	output logic [ECHO_W-1:0]        grant_gap
);

	localparam int WORDS = (MAX_PACKETS + WORD_W - 1) / WORD_W;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PW    = (MAX_PACKETS >= (1 << FLOW_W)) ? FLOW_W : $clog2(MAX_PACKETS + 1);
	localparam int QW    = AW + BIT_W + 1;
	localparam int DW    = ((GRANT_BITS > ECHO_W) ? GRANT_BITS : ECHO_W) + 2;

	// configuration
	logic [FLOW_W-1:0] flow_q;
	logic [FLOW_W-1:0] goal_q;
	logic [FLOW_W-1:0] limit_q;

	// flow state
	logic [AW-1:0]            clr_addr_q;
	logic [PW-1:0]            ptr_q;
	logic [PW-1:0]            count_q;
	logic [PW-1:0]            next_start_q;
	logic [GRANT_BITS-1:0]    grants_q;
	logic signed [ECHO_W-1:0] largest_echo_q;
	logic                     rts_seen_q;
	logic                     done_q;

	// current request
	logic [CMD_W-1:0]         cmd_q;
	logic [DNUM_W-1:0]        dnum_q;
	logic signed [ECHO_W-1:0] echo_q;
	logic [PW-1:0]            scan_pos_q;
	logic                     dup_q;
	logic [TGT_W-1:0]         target_q;
	logic [GNUM_W-1:0]        gnum_q;
	logic                     none_q;

	// ram ports
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	// combinational helpers
	logic [PW-1:0]     n_eff;
	logic [AW-1:0]     dnum_word;
	logic [QW-1:0]     sp;
	logic [QW-1:0]     nq;
	logic [AW-1:0]     scan_word;
	logic [WORD_W-1:0] free_bits;
	logic [WORD_W-1:0] low_bit;
	logic              any_free;
	logic [QW-1:0]     free_pos;
	logic [QW-1:0]     next_base;
	logic              start_past;
	logic [PW-1:0]     hit_pos;
	logic [PW:0]       hit_inc;
	logic              done_nx;
	logic [PW-1:0]     remain;
	logic [DW-1:0]     grants_ext;
	logic [DW-1:0]     echo_ext;
	logic [DW-1:0]     gap_full;
	logic [PW-1:0]     mod_rem;
	logic              mod_busy;

	// one-hot to index encoder
	function automatic logic [BIT_W-1:0] enc_onehot(input logic [WORD_W-1:0] oh);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int j = 0; j < WORD_W; j++) begin
			for (int k = 0; k < BIT_W; k++) begin
				if (j[k]) begin
					r[k] = r[k] | oh[j];
				end
			end
		end
		return r;
	endfunction

	// effective flow size, clamped to the bitmap size
	assign n_eff = (32'(flow_q) > MAX_PACKETS) ? PW'(MAX_PACKETS) : PW'(flow_q);

	// word scanner: first missing packet at or after the scan position
	assign dnum_word = AW'(dnum_q[DNUM_W-1:BIT_W]);
	assign sp        = QW'(scan_pos_q);
	assign nq        = QW'(n_eff);
	assign scan_word = sp[AW+BIT_W-1:BIT_W];
	assign free_bits = ~ram_rdata & ({WORD_W{1'b1}} << sp[BIT_W-1:0]);
	assign low_bit   = free_bits & (~free_bits + 1'b1);
	assign any_free  = |free_bits;
	assign free_pos  = {sp[QW-1:BIT_W], enc_onehot(low_bit)};
	assign next_base = {sp[QW-1:BIT_W] + 1'b1, {BIT_W{1'b0}}};
	assign start_past = (sp >= nq);
	assign hit_pos   = PW'(free_pos);
	assign hit_inc   = {1'b0, hit_pos} + 1'b1;

	// status to the controller
	always_comb begin
		st.clr_last   = (clr_addr_q == AW'(WORDS - 1));
		st.cmd        = cmd_q;
		st.dnum_ok    = (32'(dnum_q) < MAX_PACKETS);
		st.bit_set    = ram_rdata[dnum_q[BIT_W-1:0]];
		st.ptr_lt_n   = (ptr_q < n_eff);
		st.n_zero     = (n_eff == '0);
		st.start_lt_n = (next_start_q < n_eff);
		st.scan_found = !start_past && any_free && (free_pos < nq);
		st.scan_ended = start_past || (any_free && (free_pos >= nq)) ||
			(!any_free && (next_base >= nq));
		st.mod_busy   = mod_busy;
	end

	// ram port selection
	always_comb begin
		ram_we    = cmd.clr_we | cmd.mark;
		ram_waddr = cmd.clr_we ? clr_addr_q : dnum_word;
		ram_wdata = cmd.clr_we ? '0 :
			(ram_rdata | ({{(WORD_W-1){1'b0}}, 1'b1} << dnum_q[BIT_W-1:0]));
		if (cmd.rd_data) begin
			ram_raddr = dnum_word;
		end else if (cmd.scan_rd) begin
			ram_raddr = scan_word;
		end else begin
			ram_raddr = scan_word + 1'b1;
		end
	end

	// reported values after the request
	assign done_nx    = done_q | ((cmd_q == CMD_DATA) && (32'(count_q) >= 32'(goal_q)));
	assign remain     = (n_eff > count_q) ? (n_eff - count_q) : '0;
	assign grants_ext = {{(DW-GRANT_BITS){1'b0}}, grants_q};
	assign echo_ext   = {{(DW-ECHO_W){largest_echo_q[ECHO_W-1]}}, largest_echo_q};
	assign gap_full   = grants_ext - echo_ext;

	// configuration and flow state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_q         <= FLOW_PACKETS_RST;
			goal_q         <= DONE_GOAL_RST;
			limit_q        <= WINDOW_LIMIT_RST;
			clr_addr_q     <= '0;
			ptr_q          <= '0;
			count_q        <= '0;
			next_start_q   <= '0;
			grants_q       <= '0;
			largest_echo_q <= '1;
			rts_seen_q     <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FLOW_PACKETS: flow_q  <= cfg_data;
					CFG_DONE_GOAL:    goal_q  <= cfg_data;
					CFG_WINDOW_LIMIT: limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clr_we) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.rts_preset && !rts_seen_q) begin
				rts_seen_q   <= 1'b1;
				grants_q     <= (32'(n_eff) <= 32'(limit_q)) ? GRANT_BITS'(n_eff) : '0;
				next_start_q <= '0;
			end
			if (cmd.echo_upd && (echo_q > largest_echo_q)) begin
				largest_echo_q <= echo_q;
			end
			if (cmd.mark) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.ptr_found) begin
				ptr_q <= hit_pos;
			end else if (cmd.ptr_end) begin
				ptr_q <= n_eff;
			end
			if (cmd.grant_issue) begin
				next_start_q <= (hit_inc >= {1'b0, n_eff}) ? '0 : PW'(hit_inc);
				grants_q     <= grants_q + 1'b1;
			end
			if (cmd.out_load) begin
				done_q <= done_nx;
			end
		end
	end

	// request capture, per-request results and result register
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			cmd_q    <= in_cmd;
			dnum_q   <= in_data_number;
			echo_q   <= in_echoed_grant;
			dup_q    <= 1'b0;
			target_q <= '0;
			gnum_q   <= '0;
			none_q   <= 1'b0;
		end
		if (cmd.set_dup) begin
			dup_q <= 1'b1;
		end
		if (cmd.scan_ptr) begin
			scan_pos_q <= ptr_q;
		end else if (cmd.scan_start) begin
			scan_pos_q <= next_start_q;
		end else if (cmd.scan_rem) begin
			scan_pos_q <= mod_rem;
		end else if (cmd.scan_next) begin
			scan_pos_q <= PW'(next_base);
		end
		if (cmd.grant_issue) begin
			target_q <= TGT_W'(hit_pos);
			gnum_q   <= GNUM_W'(grants_q);
		end
		if (cmd.grant_none) begin
			none_q <= 1'b1;
		end
		if (cmd.out_load) begin
			was_duplicate     <= dup_q;
			flow_done         <= done_nx;
			in_order_point    <= FLOW_W'(ptr_q);
			arrival_count     <= FLOW_W'(count_q);
			remaining_packets <= FLOW_W'(remain);
			grant_target      <= target_q;
			grant_number      <= gnum_q;
			grant_none        <= none_q;
			grant_gap         <= gap_full[DW-1] ? '0 : gap_full[ECHO_W-1:0];
		end
	end

	// arrival bitmap, one 64-bit word per row
	rgp_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORDS),
		.AW    (AW)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// grant start pointer modulo flow size
	rgp_mod #(
		.W (PW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (next_start_q),
		.divisor  (n_eff),
		.busy     (mod_busy),
		.rem      (mod_rem)
	);

endmodule

>>> rtl/core/rgp_ctrl.sv
// controller: sequences clearing, request decode, bitmap scans and result handoff
module rgp_ctrl import rgp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t st,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_DATA_RD,
		ST_DATA_CHK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_MOD,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		SM_ADV,
		SM_GR1,
		SM_GR2
	} mode_t;

	state_t state_q, nxt;
	mode_t  mode_q, nxt_mode;
	logic   in_ready_q;
	logic   out_valid_q;

	// next state and datapath commands
	always_comb begin
		cmd      = '0;
		nxt      = state_q;
		nxt_mode = mode_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (st.clr_last) begin
					nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid && in_ready_q) begin
					cmd.cap_in = 1'b1;
					nxt        = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (st.cmd)
					CMD_RTS: begin
						cmd.rts_preset = 1'b1;
						nxt            = ST_FIN;
					end
					CMD_DATA: begin
						cmd.rts_preset = 1'b1;
						cmd.echo_upd   = 1'b1;
						nxt            = st.dnum_ok ? ST_DATA_RD : ST_FIN;
					end
					CMD_GRANT: begin
						nxt_mode = SM_GR1;
						if (st.n_zero) begin
							cmd.grant_none = 1'b1;
							nxt            = ST_FIN;
						end else if (st.start_lt_n) begin
							cmd.scan_start = 1'b1;
							nxt            = ST_SCAN_RD;
						end else begin
							cmd.mod_start = 1'b1;
							nxt           = ST_MOD;
						end
					end
					default: begin
						nxt = ST_FIN;
					end
				endcase
			end
			ST_DATA_RD: begin
				cmd.rd_data = 1'b1;
				nxt         = ST_DATA_CHK;
			end
			ST_DATA_CHK: begin
				if (st.bit_set) begin
					cmd.set_dup = 1'b1;
					nxt         = ST_FIN;
				end else begin
					cmd.mark = 1'b1;
					if (st.ptr_lt_n) begin
						cmd.scan_ptr = 1'b1;
						nxt_mode     = SM_ADV;
						nxt          = ST_SCAN_RD;
					end else begin
						nxt = ST_FIN;
					end
				end
			end
			ST_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				nxt         = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				priority if (st.scan_found) begin
					if (mode_q == SM_ADV) begin
						cmd.ptr_found = 1'b1;
					end else begin
						cmd.grant_issue = 1'b1;
					end
					nxt = ST_FIN;
				end else if (st.scan_ended) begin
					unique case (mode_q)
						SM_ADV: begin
							cmd.ptr_end = 1'b1;
							nxt         = ST_FIN;
						end
						SM_GR1: begin
							// wrap the search back to the in-order pointer
							if (st.ptr_lt_n) begin
								cmd.scan_ptr = 1'b1;
								nxt_mode     = SM_GR2;
								nxt          = ST_SCAN_RD;
							end else begin
								cmd.grant_none = 1'b1;
								nxt            = ST_FIN;
							end
						end
						default: begin
							cmd.grant_none = 1'b1;
							nxt            = ST_FIN;
						end
					endcase
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			ST_MOD: begin
				if (!st.mod_busy) begin
					cmd.scan_rem = 1'b1;
					nxt          = ST_SCAN_RD;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					nxt          = ST_IDLE;
				end
			end
			default: begin
				nxt = ST_IDLE;
			end
		endcase
	end

	// state and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			mode_q      <= SM_ADV;
			in_ready_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= nxt;
			mode_q     <= nxt_mode;
			in_ready_q <= (nxt == ST_IDLE);
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/receiver_bitmap_grant_picker.sv
// top level of the receiver bitmap grant picker
// Per-flow receiver state: an arrival bitmap, in-order pointer, arrival count
// and grant bookkeeping. Requests come in on in_valid/in_ready with cmd
// (rts, data arrival, grant opportunity), data_number and echoed_grant; one
// result per request leaves on out_valid/out_ready. Registers are written on
// cfg_valid/cfg_ready (always ready) with cfg_index and cfg_data; the user
// must write them only while idle, which the block itself does not enforce.
// Sequence: rts, the unused command and an out-of-range data number go from
// decode straight to the result. A new data arrival reads its bitmap word,
// marks it and, with the in-order pointer short of the flow end, sweeps the
// bitmap word by word for the next missing packet; a duplicate, or one with
// the pointer at the flow end, skips the sweep. A grant searches word by word
// from its start point to the flow end and, if none is found, in a second
// pass from the in-order pointer to the flow end; a start point at or past
// the flow size is first reduced modulo the flow size. One request is in
// flight at a time; the next is accepted the cycle after the result is loaded.
// Reset: a clearing pass writes every bitmap word to zero; no request is
// accepted meanwhile.
// Stall: a result waits in the output register; a finished request waits for
// it to be taken while in_ready stays low.
module receiver_bitmap_grant_picker import rgp_pkg::*; #(
	parameter int MAX_PACKETS = MAX_PACKETS_DEF,
	parameter int GRANT_BITS  = GRANT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [FLOW_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [DNUM_W-1:0]        data_number,
	input  logic signed [ECHO_W-1:0] echoed_grant,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     was_duplicate,
	output logic                     flow_done,
	output logic [FLOW_W-1:0]        in_order_point,
	output logic [FLOW_W-1:0]        arrival_count,
	output logic [FLOW_W-1:0]        remaining_packets,
	output logic [TGT_W-1:0]         grant_target,
	output logic [GNUM_W-1:0]        grant_number,
	output logic                     grant_none,
	output logic [ECHO_W-1:0]        grant_gap
);

	ctrl_cmd_t  ctl;
	dp_status_t st;

	// configuration writes are taken in any state
	assign cfg_ready = 1'b1;

	// sequencer
	rgp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (ctl)
	);

	// state, bitmap and result datapath
	rgp_datapath #(
		.MAX_PACKETS (MAX_PACKETS),
		.GRANT_BITS  (GRANT_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (ctl),
		.st                (st),
		.cfg_we            (cfg_valid & cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_cmd            (cmd),
		.in_data_number    (data_number),
		.in_echoed_grant   (echoed_grant),
		.was_duplicate     (was_duplicate),
		.flow_done         (flow_done),
		.in_order_point    (in_order_point),
		.arrival_count     (arrival_count),
		.remaining_packets (remaining_packets),
		.grant_target      (grant_target),
		.grant_number      (grant_number),
		.grant_none        (grant_none),
		.grant_gap         (grant_gap)
	);

endmodule

>>> verif/receiver_bitmap_grant_picker_test.sv
// self-checking testbench of the receiver bitmap grant picker: directed script, random phases
`timescale 1ns / 100ps

module receiver_bitmap_grant_picker_test;
	import rgp_pkg::*;

	localparam int BITMAP_SIZE = MAX_PACKETS_DEF;
	localparam int GRANT_MASK  = (1 << GRANT_BITS_DEF) - 1;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 200;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 95;
	localparam logic [CMD_W-1:0]     CMD_UNUSED     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic [DNUM_W-1:0]        dnum;
		logic signed [ECHO_W-1:0] echo;
	} flow_request_t;

	typedef struct packed {
		logic              dup;
		logic              done;
		logic [FLOW_W-1:0] iop;
		logic [FLOW_W-1:0] cnt;
		logic [FLOW_W-1:0] rem;
		logic [TGT_W-1:0]  tgt;
		logic [GNUM_W-1:0] gnum;
		logic              none;
		logic [ECHO_W-1:0] gap;
	} flow_report_t;

	typedef struct {
		bit                   is_write;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [FLOW_W-1:0]    reg_val;
		flow_request_t        req;
		bit                   known;
		flow_report_t         want;
	} script_row_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	// block inputs, known from time zero
	logic                     cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [FLOW_W-1:0]        cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic [CMD_W-1:0]         cmd = CMD_RTS;
	logic [DNUM_W-1:0]        data_number = '0;
	logic signed [ECHO_W-1:0] echoed_grant = '0;
	logic                     out_ready = 1'b1;

	// block outputs
	logic                     cfg_ready;
	logic                     in_ready;
	logic                     out_valid;
	logic                     was_duplicate;
	logic                     flow_done;
	logic [FLOW_W-1:0]        in_order_point;
	logic [FLOW_W-1:0]        arrival_count;
	logic [FLOW_W-1:0]        remaining_packets;
	logic [TGT_W-1:0]         grant_target;
	logic [GNUM_W-1:0]        grant_number;
	logic                     grant_none;
	logic [ECHO_W-1:0]        grant_gap;

	receiver_bitmap_grant_picker uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.data_number(data_number),
		.echoed_grant(echoed_grant),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.was_duplicate(was_duplicate),
		.flow_done(flow_done),
		.in_order_point(in_order_point),
		.arrival_count(arrival_count),
		.remaining_packets(remaining_packets),
		.grant_target(grant_target),
		.grant_number(grant_number),
		.grant_none(grant_none),
		.grant_gap(grant_gap)
	);

	// predicted flow state and register copies
	bit arrived_seen [BITMAP_SIZE];
	int in_order;
	int distinct;
	int grant_start;
	int grants_out;
	int top_echo;
	bit rts_done;
	bit flow_complete;
	int flow_reg;
	int goal_reg;
	int window_reg;

	flow_report_t awaited_reports [$];
	script_row_t  script [$];
	int  mismatches = 0;
	int  quiet_cycles = 0;
	int  stall_left = 0;
	bit  in_gaps_on = 1'b1;
	bit  out_stalls_on = 1'b1;
	bit  wide_echo = 1'b0;

	// initial-window preset, taken once per flow
	function automatic void preset_grants(input int n);
		if (!rts_done) begin
			rts_done = 1'b1;
			grants_out = ((n <= window_reg) ? n : 0) & GRANT_MASK;
			grant_start = 0;
		end
	endfunction

	// advance the predicted flow by one request and build its report
	function automatic flow_report_t next_flow_report(input flow_request_t r);
		int n;
		int pos;
		int steps;
		int e;
		int gap;
		bit found;
		flow_report_t o;
		o = '0;
		n = (flow_reg > BITMAP_SIZE) ? BITMAP_SIZE : flow_reg;
		e = $signed(r.echo);
		case (r.cmd)
			CMD_RTS: begin
				preset_grants(n);
			end
			CMD_DATA: begin
				preset_grants(n);
				if (arrived_seen[r.dnum]) begin
					o.dup = 1'b1;
				end else begin
					arrived_seen[r.dnum] = 1'b1;
					distinct++;
					while (in_order < n && in_order < BITMAP_SIZE && arrived_seen[in_order])
						in_order++;
				end
				if (e > top_echo)
					top_echo = e;
				if (distinct >= goal_reg)
					flow_complete = 1'b1;
			end
			CMD_GRANT: begin
				found = 1'b0;
				pos = 0;
				if (n > 0) begin
					pos = grant_start % n;
					for (steps = 0; steps < n; steps++) begin
						if (pos >= n)
							break;
						if (!arrived_seen[pos]) begin
							found = 1'b1;
							break;
						end
						pos++;
						if (pos >= n)
							pos = in_order;
					end
				end
				if (found) begin
					o.tgt = TGT_W'(pos);
					o.gnum = GNUM_W'(grants_out);
					grant_start = (pos + 1 >= n) ? 0 : pos + 1;
					grants_out = (grants_out + 1) & GRANT_MASK;
				end else begin
					o.none = 1'b1;
				end
			end
			default: ;
		endcase
		gap = grants_out - top_echo;
		if (gap < 0)
			gap = 0;
		o.done = flow_complete;
		o.iop = FLOW_W'(in_order);
		o.cnt = FLOW_W'(distinct);
		o.rem = FLOW_W'((n > distinct) ? n - distinct : 0);
		o.gap = ECHO_W'(gap);
		return o;
	endfunction

	// random request, biased toward packets just past the in-order point
	function automatic flow_request_t draw_request();
		int n;
		int sel;
		int hi;
		flow_request_t r;
		n = (flow_reg > BITMAP_SIZE) ? BITMAP_SIZE : flow_reg;
		sel = $urandom_range(0, 99);
		if (sel < 5)
			r.cmd = CMD_RTS;
		else if (sel < 10)
			r.cmd = CMD_UNUSED;
		else if (sel < 55)
			r.cmd = CMD_DATA;
		else
			r.cmd = CMD_GRANT;
		sel = $urandom_range(0, 99);
		if (sel < 70 && in_order < n) begin
			hi = (in_order + 40 < n) ? in_order + 40 : n - 1;
			r.dnum = DNUM_W'($urandom_range(in_order, hi));
		end else if (sel < 85 && n > 0) begin
			r.dnum = DNUM_W'($urandom_range(0, n - 1));
		end else begin
			r.dnum = DNUM_W'($urandom_range(0, BITMAP_SIZE - 1));
		end
		sel = $urandom_range(0, 99);
		if (wide_echo && sel < 25)
			r.echo = ECHO_W'($urandom());
		else if (sel < 60)
			r.echo = ECHO_W'(-1);
		else
			r.echo = ECHO_W'($urandom_range(0, grants_out + 4));
		return r;
	endfunction

	// script entries
	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input int val);
		script_row_t s;
		s = '{default: '0};
		s.is_write = 1'b1;
		s.reg_idx = idx;
		s.reg_val = FLOW_W'(val);
		script = {script, s};
	endfunction

	function automatic void add_req(input logic [CMD_W-1:0] c, input int dn, input int ec,
			input bit known = 1'b0, input flow_report_t want = '0);
		script_row_t s;
		s = '{default: '0};
		s.req.cmd = c;
		s.req.dnum = DNUM_W'(dn);
		s.req.echo = ECHO_W'(ec);
		s.known = known;
		s.want = want;
		script = {script, s};
	endfunction

	// one register write, then the channel goes quiet before the task returns
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FLOW_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FLOW_PACKETS: flow_reg = val;
			CFG_DONE_GOAL:    goal_reg = val;
			CFG_WINDOW_LIMIT: window_reg = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// offer one request after a random gap and queue its predicted report
	task automatic send_request(input flow_request_t r, input bit known, input flow_report_t want);
		int gap;
		flow_report_t pred;
		gap = in_gaps_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= r.cmd;
		data_number <= r.dnum;
		echoed_grant <= r.echo;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pred = next_flow_report(r);
		awaited_reports = {awaited_reports, (known ? want : pred)};
	endtask

	// hold the sender until every report is back and the block is idle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin
		flow_report_t got;
		flow_report_t want;
		int stall;
		if (out_valid && out_ready) begin
			got = '{was_duplicate, flow_done, in_order_point, arrival_count, remaining_packets,
				grant_target, grant_number, grant_none, grant_gap};
			if (awaited_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected report at %0t", $realtime);
			end else begin
				want = awaited_reports.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("report mismatch at %0t", $realtime);
						$write("  expected dup %0d done %0d iop %0d cnt %0d rem %0d",
							want.dup, want.done, want.iop, want.cnt, want.rem);
						$display(" tgt %0d gnum %0d none %0d gap %0d",
							want.tgt, want.gnum, want.none, want.gap);
						$write("  actual   dup %0d done %0d iop %0d cnt %0d rem %0d",
							got.dup, got.done, got.iop, got.cnt, got.rem);
						$display(" tgt %0d gnum %0d none %0d gap %0d",
							got.tgt, got.gnum, got.none, got.gap);
					end
				end
			end
			stall = out_stalls_on ? $urandom_range(0, 7) : 0;
			stall_left <= stall;
			out_ready <= (stall == 0);
		end else if (out_valid && !out_ready) begin
			if (stall_left > 1)
				stall_left <= stall_left - 1;
			else
				out_ready <= 1'b1;
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int i;
		int ph;
		int k;
		int goal;
		int phase_flow [PHASES];
		phase_flow = '{12, 40, 64, 65, 130, 260, 700, 1500, 4096, 8191};

		// predicted state after reset
		for (i = 0; i < BITMAP_SIZE; i++)
			arrived_seen[i] = 1'b0;
		in_order = 0;
		distinct = 0;
		grant_start = 0;
		grants_out = 0;
		top_echo = -1;
		rts_done = 1'b0;
		flow_complete = 1'b0;
		flow_reg = FLOW_PACKETS_RST;
		goal_reg = DONE_GOAL_RST;
		window_reg = WINDOW_LIMIT_RST;

		// directed script: reset state, tiny flow, wrap, zero and oversized flow, stale pointer
		add_req(CMD_UNUSED, 4095, -1, 1'b1, '{1'b0, 1'b0, 13'd0, 13'd0, 13'd4096,
			12'd0, 16'd0, 1'b0, 17'd1});
		add_write(CFG_FLOW_PACKETS, 4);
		add_write(CFG_DONE_GOAL, 8191);
		add_write(CFG_WINDOW_LIMIT, 8191);
		add_write(CFG_UNUSED_IDX, 0);
		add_req(CMD_RTS, 0, 0, 1'b1, '{1'b0, 1'b0, 13'd0, 13'd0, 13'd4,
			12'd0, 16'd0, 1'b0, 17'd5});
		add_req(CMD_RTS, 4095, -1);
		add_req(CMD_GRANT, 0, 0);
		add_req(CMD_DATA, 0, -1);
		add_req(CMD_DATA, 0, -65536);
		add_req(CMD_DATA, 3, 2);
		add_req(CMD_GRANT, 0, 0);
		add_req(CMD_GRANT, 4095, -1);
		add_req(CMD_GRANT, 0, 0);
		add_req(CMD_DATA, 1, 0);
		add_req(CMD_DATA, 2, 5);
		add_req(CMD_GRANT, 0, 0);
		add_req(CMD_DATA, 4095, 1);
		add_write(CFG_FLOW_PACKETS, 0);
		add_req(CMD_GRANT, 0, 0);
		add_req(CMD_DATA, 10, 3);
		add_write(CFG_FLOW_PACKETS, 8191);
		add_req(CMD_GRANT, 0, 0);
		add_write(CFG_FLOW_PACKETS, 3);
		add_req(CMD_GRANT, 0, 0);
		add_write(CFG_DONE_GOAL, 4096);
		add_write(CFG_WINDOW_LIMIT, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the script, settling the block before every register write
		foreach (script[i]) begin
			if (script[i].is_write) begin
				drain();
				write_reg(script[i].reg_idx, script[i].reg_val);
			end else begin
				send_request(script[i].req, script[i].known, script[i].want);
			end
		end

		// random phases over growing flow sizes
		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			if (ph < 5)
				goal = $urandom_range(0, 1) ? 4096 : 8191;
			else if (ph == 7)
				goal = 1;
			else
				goal = distinct + $urandom_range(0, 40);
			write_reg(CFG_FLOW_PACKETS, FLOW_W'(phase_flow[ph]));
			write_reg(CFG_DONE_GOAL, FLOW_W'(goal));
			write_reg(CFG_WINDOW_LIMIT, FLOW_W'($urandom_range(0, 8191)));
			in_gaps_on = ($urandom_range(0, 3) != 0);
			out_stalls_on = ($urandom_range(0, 3) != 0);
			wide_echo = (ph == PHASES - 1);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 39) == 0)
					drain();
				send_request(draw_request(), 1'b0, '0);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_reports.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
